/* design/rsvm_pkg.sv */
// Shared types and constants for the register stack machine execute core
package rsvm_pkg;

  typedef enum logic [3:0] {
    OP_ZERO   = 4'd0,
    OP_NOP    = 4'd1,
    OP_PUSH   = 4'd2,
    OP_POP    = 4'd3,
    OP_ADD    = 4'd4,
    OP_SUB    = 4'd5,
    OP_MUL    = 4'd6,
    OP_DIV    = 4'd7,
    OP_MOV    = 4'd8,
    OP_PUTNUM = 4'd9,
    OP_PUTSTR = 4'd10,
    OP_JMP    = 4'd11,
    OP_JZ     = 4'd12,
    OP_LABEL  = 4'd13,
    OP_JNZ    = 4'd14,
    OP_HALT   = 4'd15
  } op_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_POP_EMPTY = 3'd1,
    ERR_DIV_ZERO  = 3'd2,
    ERR_STACK_FUL = 3'd3,
    ERR_STEP_LIM  = 3'd4,
    ERR_BAD_MODE  = 3'd5
  } err_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_e;

  localparam logic [31:0] LimitReset = 32'd50000000;
  localparam int unsigned PcWidth = 11;
  localparam int unsigned TargetWidth = 10;
  localparam int unsigned DataWidth = 64;

endpackage

/* design/register_stack_vm_execute_core.sv */
// Execute core of a small register and stack machine
//
//  channel      | dir | handshake                | payload
//  s_axis       | in  | s_axis_tvalid/tready     | tdata: mode,dest_reg,src_is_reg,src_reg,
//               |     |                          |        immediate,jump_target
//  m_axis       | out | m_axis_tvalid/tready     | tdata: next_pc,print_value,error_code
//               |     |                          | tuser: print_valid,halted
//  cfg          | in  | cfg_valid_i/cfg_ready_o  | step_limit
//
// An item reads the register file, then executes and writes back; MUL adds a step of
// 32x32 partial products, DIV adds a radix-2 divider.
// One item at a time: the next item is taken once the core is back in idle.
// The result register holds a stalled result; the input side takes the next item as
// soon as that register is loaded, and that item waits in its last cycle until the
// register is free. Reset (async, active low) resets the control registers and valid bits;
// the register file and value stack memories are not cleared.
module register_stack_vm_execute_core #(
  parameter int unsigned REG_COUNT     = 8,
  parameter int unsigned STACK_DEPTH   = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // mode[3:0], dest_reg[6:4], src_is_reg[7], src_reg[10:8], immediate[74:11],
  // jump_target[84:75]
  input  logic [87:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // next_pc[10:0], print_value[74:11], error_code[77:75]
  output logic [79:0]  m_axis_tdata,
  // print_valid[0], halted[1]
  output logic [1:0]   m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [31:0]  cfg_data_i
);

  // register numbers are 3 bits wide, so at most eight registers are reachable
  localparam int unsigned RegN  = (REG_COUNT > 8) ? 8 : REG_COUNT;
  localparam int unsigned RegAw = $clog2(RegN);
  localparam int unsigned StkAw = $clog2(STACK_DEPTH);
  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned TgtW  = rsvm_pkg::TargetWidth;
  localparam int unsigned PcW   = rsvm_pkg::PcWidth;
  localparam int unsigned DW    = rsvm_pkg::DataWidth;

  // register file and stack: synchronous memories
  logic [DW-1:0] rf_mem [RegN];
  logic [DW-1:0] stk_mem [STACK_DEPTH];
  logic [RegN-1:0] rf_vld_q;  // entry written since reset
  logic [DW-1:0] rf_dst_rd_q, rf_src_rd_q, stk_rd_q;
  logic rf_we;
  logic [RegAw-1:0] rf_wa;
  logic [DW-1:0] rf_wd;
  logic stk_we;
  logic [StkAw-1:0] stk_wa;

  rsvm_pkg::state_e state_q, state_d;
  logic [3:0] mode_q;
  logic [2:0] dst_q, srcr_q;
  logic src_is_reg_q;
  logic [DW-1:0] imm_q;
  logic [TgtW-1:0] tgt_q;
  logic [PcW-1:0] pc_q, pc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0] steps_q, steps_d, limit_q;
  logic stopped_q, stopped_d;
  logic [DW-1:0] a_q, b_q, acc_d, acc_q, rem_q;
  logic [1:0] mstep_q;
  logic [6:0] dstep_q;
  logic neg_q;
  logic out_vld_q;
  logic [PcW-1:0] o_pc_q;
  logic [DW-1:0] o_pval_q;
  logic o_pvld_q, o_halt_q;
  logic [2:0] o_err_q;
  logic load_out;
  logic [PcW-1:0] o_pc_d;
  logic [DW-1:0] o_pval_d;
  logic o_pvld_d;
  logic [2:0] o_err_d;
  logic start_mul, start_div;
  logic out_free;
  logic [DW-1:0] dval, sval;

  // restoring divider: quotient bits shift into a_q
  logic [DW:0] div_try;
  logic [DW-1:0] div_rem;
  logic div_bit;

  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == rsvm_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  // the result register can take a new result this cycle
  assign out_free = !out_vld_q || m_axis_tready;

  // register numbers beyond REG_COUNT read as zero and are not written
  function automatic logic reg_ok(input logic [2:0] r);
    reg_ok = ({29'd0, r} < REG_COUNT);
  endfunction

  // registered reads are qualified by validity and range
  function automatic logic [DW-1:0] src_val_reg();
    src_val_reg = (reg_ok(srcr_q) && rf_vld_q[srcr_q[RegAw-1:0]]) ? rf_src_rd_q : '0;
  endfunction

  assign dval = (reg_ok(dst_q) && rf_vld_q[dst_q[RegAw-1:0]]) ? rf_dst_rd_q : '0;
  assign sval = src_is_reg_q ? src_val_reg() : imm_q;

  assign div_try = {rem_q, a_q[DW-1]} - {1'b0, b_q};
  assign div_bit = !div_try[DW];
  assign div_rem = div_bit ? div_try[DW-1:0] : {rem_q[DW-2:0], a_q[DW-1]};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rf_dst_rd_q <= rf_mem[s_axis_tdata[4+RegAw-1:4]];
      rf_src_rd_q <= rf_mem[s_axis_tdata[8+RegAw-1:8]];
      if (cnt_q != '0) stk_rd_q <= stk_mem[StkAw'(cnt_q - CntW'(1))];
    end
    if (rf_we) rf_mem[rf_wa] <= rf_wd;
    if (stk_we) stk_mem[stk_wa] <= sval;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rsvm_pkg::ST_IDLE;
      pc_q <= '0;
      cnt_q <= '0;
      steps_q <= '0;
      stopped_q <= 1'b0;
      limit_q <= rsvm_pkg::LimitReset;
      out_vld_q <= 1'b0;
      rf_vld_q <= '0;
    end else begin
      state_q <= state_d;
      pc_q <= pc_d;
      cnt_q <= cnt_d;
      steps_q <= steps_d;
      stopped_q <= stopped_d;
      if (cfg_valid_i) limit_q <= cfg_data_i;
      if (load_out) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
      if (rf_we) rf_vld_q[rf_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= s_axis_tdata[3:0];
      dst_q <= s_axis_tdata[6:4];
      src_is_reg_q <= s_axis_tdata[7];
      srcr_q <= s_axis_tdata[10:8];
      imm_q <= s_axis_tdata[74:11];
      tgt_q <= s_axis_tdata[75+TgtW-1:75];
    end
    if (load_out) begin
      o_pc_q <= o_pc_d;
      o_pval_q <= o_pval_d;
      o_pvld_q <= o_pvld_d;
      o_halt_q <= stopped_d;
      o_err_q <= o_err_d;
    end
    acc_q <= acc_d;
    if (start_mul) begin
      a_q <= dval;
      b_q <= sval;
      mstep_q <= '0;
    end else if (state_q == rsvm_pkg::ST_MUL && mstep_q != 2'd3) begin
      mstep_q <= mstep_q + 2'd1;
    end
    if (start_div) begin
      a_q <= dval[DW-1] ? (DW'(0) - dval) : dval;
      b_q <= sval[DW-1] ? (DW'(0) - sval) : sval;
      neg_q <= dval[DW-1] ^ sval[DW-1];
      rem_q <= '0;
      dstep_q <= '0;
    end else if (state_q == rsvm_pkg::ST_DIV && dstep_q != 7'd64) begin
      rem_q <= div_rem;
      a_q <= {a_q[DW-2:0], div_bit};
      dstep_q <= dstep_q + 7'd1;
    end
  end

  // 64x64 low product from three 32x32 partial products, one per cycle
  logic [31:0] pa, pb;
  logic [63:0] pp;
  always_comb begin
    case (mstep_q)
      2'd0: begin pa = a_q[31:0];  pb = b_q[31:0];  end
      2'd1: begin pa = a_q[63:32]; pb = b_q[31:0];  end
      2'd2: begin pa = a_q[31:0];  pb = b_q[63:32]; end
      default: begin pa = '0; pb = '0; end
    endcase
  end
  assign pp = pa * pb;

  always_comb begin
    logic [PcW-1:0] nxt;
    logic [2:0] err;
    logic halt_now;
    state_d = state_q;
    pc_d = pc_q;
    cnt_d = cnt_q;
    steps_d = steps_q;
    stopped_d = stopped_q;
    load_out = 1'b0;
    o_pc_d = pc_q;
    o_pval_d = '0;
    o_pvld_d = 1'b0;
    o_err_d = rsvm_pkg::ERR_NONE;
    rf_we = 1'b0;
    rf_wa = dst_q[RegAw-1:0];
    rf_wd = '0;
    stk_we = 1'b0;
    stk_wa = cnt_q[StkAw-1:0];
    start_mul = 1'b0;
    start_div = 1'b0;
    acc_d = acc_q;
    nxt = pc_q + PcW'(1);
    err = rsvm_pkg::ERR_NONE;
    halt_now = 1'b0;
    case (state_q)
      rsvm_pkg::ST_IDLE: if (accept) state_d = rsvm_pkg::ST_EXEC;
      rsvm_pkg::ST_EXEC: if (out_free) begin
        if (stopped_q) begin
          load_out = 1'b1;
          state_d = rsvm_pkg::ST_IDLE;
        end else if ({1'b0, steps_q} + 33'd1 > {1'b0, limit_q}) begin
          err = rsvm_pkg::ERR_STEP_LIM;
        end else begin
          steps_d = steps_q + 32'd1;
          case (rsvm_pkg::op_e'(mode_q))
            rsvm_pkg::OP_NOP, rsvm_pkg::OP_PUTSTR, rsvm_pkg::OP_LABEL: ;
            rsvm_pkg::OP_PUSH:
              if (cnt_q >= CntW'(STACK_DEPTH)) err = rsvm_pkg::ERR_STACK_FUL;
              else begin
                stk_we = 1'b1;
                cnt_d = cnt_q + CntW'(1);
              end
            rsvm_pkg::OP_POP:
              if (cnt_q == '0) err = rsvm_pkg::ERR_POP_EMPTY;
              else begin
                cnt_d = cnt_q - CntW'(1);
                rf_we = reg_ok(dst_q);
                rf_wd = stk_rd_q;
              end
            rsvm_pkg::OP_ADD: begin rf_we = reg_ok(dst_q); rf_wd = dval + sval; end
            rsvm_pkg::OP_SUB: begin rf_we = reg_ok(dst_q); rf_wd = dval - sval; end
            rsvm_pkg::OP_MOV: begin rf_we = reg_ok(dst_q); rf_wd = sval; end
            rsvm_pkg::OP_MUL: start_mul = 1'b1;
            rsvm_pkg::OP_DIV:
              if (sval == '0) err = rsvm_pkg::ERR_DIV_ZERO;
              else start_div = 1'b1;
            rsvm_pkg::OP_PUTNUM: begin o_pvld_d = 1'b1; o_pval_d = sval; end
            rsvm_pkg::OP_JMP: nxt = PcW'(tgt_q);
            rsvm_pkg::OP_JZ: if (sval == '0) nxt = PcW'(tgt_q);
            rsvm_pkg::OP_JNZ: if (sval != '0) nxt = PcW'(tgt_q);
            rsvm_pkg::OP_HALT: halt_now = 1'b1;
            default: err = rsvm_pkg::ERR_BAD_MODE;
          endcase
        end
        if (!stopped_q) begin
          if (start_mul) begin
            acc_d = '0;
            state_d = rsvm_pkg::ST_MUL;
          end else if (start_div) begin
            state_d = rsvm_pkg::ST_DIV;
          end else begin
            load_out = 1'b1;
            state_d = rsvm_pkg::ST_IDLE;
            o_err_d = err;
            if (err != rsvm_pkg::ERR_NONE || halt_now) begin
              stopped_d = 1'b1;
              o_pvld_d = 1'b0;
              o_pval_d = '0;
            end else begin
              pc_d = nxt;
              o_pc_d = nxt;
            end
          end
        end
      end
      rsvm_pkg::ST_MUL: begin
        if (mstep_q == 2'd0) acc_d = pp;
        else if (mstep_q != 2'd3) acc_d = acc_q + {pp[31:0], 32'd0};
        else if (out_free) begin
          rf_we = reg_ok(dst_q);
          rf_wd = acc_q;
          load_out = 1'b1;
          pc_d = nxt;
          o_pc_d = nxt;
          state_d = rsvm_pkg::ST_IDLE;
        end
      end
      rsvm_pkg::ST_DIV: if (dstep_q == 7'd64 && out_free) begin
        rf_we = reg_ok(dst_q);
        rf_wd = neg_q ? (DW'(0) - a_q) : a_q;
        load_out = 1'b1;
        pc_d = nxt;
        o_pc_d = nxt;
        state_d = rsvm_pkg::ST_IDLE;
      end
      default: state_d = rsvm_pkg::ST_IDLE;
    endcase
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata = {2'b00, o_err_q, o_pval_q, o_pc_q};
  assign m_axis_tuser = {o_halt_q, o_pvld_q};

endmodule

/* design/rsvm_checker.sv */
// Port-level checks for the execute core, bound into the execute core module
module rsvm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_err_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[77:75] != 3'd0 |-> m_axis_tuser[1])
    else $error("error without halt");

  a_no_print_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
    else $error("print while halted");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while one is in flight");

endmodule

bind register_stack_vm_execute_core rsvm_checker u_rsvm_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
  .m_axis_tuser(m_axis_tuser));

/* tb/sv/register_stack_vm_execute_core_test.sv */
// Self-checking testbench for the register stack machine execute core
module register_stack_vm_execute_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [9:0]       jump_target;
    logic [63:0]      immediate;
    logic [2:0]       src_reg;
    logic             src_is_reg;
    logic [2:0]       dest_reg;
    rsvm_pkg::op_e    mode;
  } instr_t;

  typedef struct packed {
    logic [10:0]      next_pc;
    logic             print_valid;
    logic [63:0]      print_value;
    logic             halted;
    rsvm_pkg::err_e   error_code;
  } outcome_t;

  typedef struct {
    instr_t           ins;
    bit               typed;
    logic [10:0]      pc_typed;
    rsvm_pkg::err_e   err_typed;
  } row_t;

  localparam logic [63:0] MinVal = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxVal = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int StackDepth = 64;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;

  // machine state as predicted
  logic [63:0] regs_q [8];
  logic [63:0] stack_q [StackDepth];
  int unsigned depth_q;
  logic [10:0] pc_q;
  longint unsigned steps_q;
  bit          stopped_q;
  logic [31:0] limit_q;

  outcome_t    pending[$];
  row_t        rows[$];
  int          errors = 0;
  int          hold_cycles = 0;
  bit          hold_arm = 1'b0;
  bit          hold_done = 1'b0;
  bit          calm = 1'b0;

  register_stack_vm_execute_core dut (.*);

  always #10 clk_i = ~clk_i;

  function automatic logic [63:0] source_of(instr_t i);
    return i.src_is_reg ? regs_q[i.src_reg] : i.immediate;
  endfunction

  function automatic logic [63:0] quot_trunc(logic [63:0] a, logic [63:0] b);
    logic [63:0] ua, ub, q;
    ua = a[63] ? -a : a;
    ub = b[63] ? -b : b;
    q = ua / ub;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  function automatic outcome_t execute_instr(instr_t i);
    outcome_t o;
    logic [63:0] src;
    logic [63:0] dv;
    bit halt_now;
    src = source_of(i);
    dv = regs_q[i.dest_reg];
    halt_now = 1'b0;
    o = '{next_pc: pc_q + 11'd1, print_valid: 1'b0, print_value: '0,
          halted: 1'b0, error_code: rsvm_pkg::ERR_NONE};
    if (stopped_q) begin
      o.next_pc = pc_q;
      o.halted = 1'b1;
      return o;
    end
    if (steps_q + 1 > limit_q) begin
      o.error_code = rsvm_pkg::ERR_STEP_LIM;
    end else begin
      steps_q++;
      case (i.mode)
        rsvm_pkg::OP_NOP, rsvm_pkg::OP_PUTSTR, rsvm_pkg::OP_LABEL: ;
        rsvm_pkg::OP_PUSH:
          if (depth_q >= StackDepth) o.error_code = rsvm_pkg::ERR_STACK_FUL;
          else begin
            stack_q[depth_q] = src;
            depth_q++;
          end
        rsvm_pkg::OP_POP:
          if (depth_q == 0) o.error_code = rsvm_pkg::ERR_POP_EMPTY;
          else begin
            depth_q--;
            regs_q[i.dest_reg] = stack_q[depth_q];
          end
        rsvm_pkg::OP_ADD: regs_q[i.dest_reg] = dv + src;
        rsvm_pkg::OP_SUB: regs_q[i.dest_reg] = dv - src;
        rsvm_pkg::OP_MUL: regs_q[i.dest_reg] = dv * src;
        rsvm_pkg::OP_DIV:
          if (src == 0) o.error_code = rsvm_pkg::ERR_DIV_ZERO;
          else regs_q[i.dest_reg] = quot_trunc(dv, src);
        rsvm_pkg::OP_MOV: regs_q[i.dest_reg] = src;
        rsvm_pkg::OP_PUTNUM: begin
          o.print_valid = 1'b1;
          o.print_value = src;
        end
        rsvm_pkg::OP_JMP: o.next_pc = {1'b0, i.jump_target};
        rsvm_pkg::OP_JZ: if (src == 0) o.next_pc = {1'b0, i.jump_target};
        rsvm_pkg::OP_JNZ: if (src != 0) o.next_pc = {1'b0, i.jump_target};
        rsvm_pkg::OP_HALT: halt_now = 1'b1;
        default: o.error_code = rsvm_pkg::ERR_BAD_MODE;
      endcase
    end
    if (o.error_code != rsvm_pkg::ERR_NONE || halt_now) begin
      stopped_q = 1'b1;
      o.next_pc = pc_q;
      o.print_valid = 1'b0;
      o.print_value = '0;
    end
    o.halted = stopped_q;
    pc_q = o.next_pc;
    return o;
  endfunction

  // output side: compare each result item with the oldest prediction
  always @(posedge clk_i) begin
    outcome_t e, a;
    if (m_axis_tvalid && m_axis_tready) begin
      a = '{next_pc: m_axis_tdata[10:0], print_valid: m_axis_tuser[0],
            print_value: m_axis_tdata[74:11], halted: m_axis_tuser[1],
            error_code: rsvm_pkg::err_e'(m_axis_tdata[77:75])};
      if (pending.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
      end else begin
        e = pending.pop_front();
        if (a.next_pc !== e.next_pc) begin
          $error("next_pc exp %0d got %0d", e.next_pc, a.next_pc); errors++;
        end
        if (a.print_valid !== e.print_valid) begin
          $error("print_valid exp %0b got %0b", e.print_valid, a.print_valid); errors++;
        end
        if (a.print_value !== e.print_value) begin
          $error("print_value exp %0h got %0h", e.print_value, a.print_value); errors++;
        end
        if (a.halted !== e.halted) begin
          $error("halted exp %0b got %0b", e.halted, a.halted); errors++;
        end
        if (a.error_code !== e.error_code) begin
          $error("error_code exp %0d got %0d", e.error_code, a.error_code); errors++;
        end
      end
    end
  end

  // receiver with random back-pressure and one long hold-off
  always @(posedge clk_i) begin
    if (hold_arm && !hold_done) begin
      hold_cycles = 400;
      hold_done = 1'b1;
    end
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles--;
    end else begin
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 6);
    end
  end

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 64'd1;
      2: return '1;
      3: return MinVal;
      4: return MaxVal;
      5: return 64'(signed'($urandom_range(0, 200)) - 100);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic instr_t mk(rsvm_pkg::op_e op, int dst, bit sir, int sr,
                                logic [63:0] imm, int jt);
    instr_t i;
    i.mode = op;
    i.dest_reg = 3'(dst);
    i.src_is_reg = sir;
    i.src_reg = 3'(sr);
    i.immediate = imm;
    i.jump_target = 10'(jt);
    return i;
  endfunction

  function automatic void add_row(instr_t ins, bit typed = 1'b0,
                                  logic [10:0] pc_typed = '0,
                                  rsvm_pkg::err_e err_typed = rsvm_pkg::ERR_NONE);
    row_t r;
    r = '{ins, typed, pc_typed, err_typed};
    rows.insert(rows.size(), r);
  endfunction

  function automatic instr_t random_instr();
    instr_t i;
    i = mk(rsvm_pkg::op_e'($urandom_range(1, 14)), $urandom_range(0, 7),
           $urandom_range(0, 1), $urandom_range(0, 7), pick_value(),
           $urandom_range(0, 1023));
    // keep the machine running: steer away from stack overflow, empty pop and divide by zero
    if (i.mode == rsvm_pkg::OP_PUSH && depth_q >= StackDepth) i.mode = rsvm_pkg::OP_POP;
    else if (i.mode == rsvm_pkg::OP_POP && depth_q == 0) i.mode = rsvm_pkg::OP_PUSH;
    else if (i.mode == rsvm_pkg::OP_DIV && source_of(i) == 0) i.mode = rsvm_pkg::OP_MUL;
    return i;
  endfunction

  task automatic send(instr_t i, bit typed = 1'b0, logic [10:0] pc_typed = '0,
                      rsvm_pkg::err_e err_typed = rsvm_pkg::ERR_NONE);
    outcome_t o;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b000, i};
    do @(posedge clk_i); while (!s_axis_tready);
    // predict at the accepting edge, in item order
    o = execute_instr(i);
    if (typed) begin
      o.next_pc = pc_typed;
      o.error_code = err_typed;
    end
    pending.insert(pending.size(), o);
    if (!calm && $urandom_range(0, 99) < 6) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    wait (pending.size() == 0);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [31:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    limit_q = v;
  endtask

  task automatic random_phase(int n);
    for (int k = 0; k < n; k++) begin
      calm = (k >= n / 3) && (k < n / 2);
      send(random_instr());
    end
    calm = 1'b0;
  endtask

  initial begin
    instr_t ins;
    int kind;
    foreach (regs_q[r]) regs_q[r] = '0;
    depth_q = 0;
    pc_q = '0;
    steps_q = 0;
    stopped_q = 1'b0;
    limit_q = rsvm_pkg::LimitReset;
    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_limit(32'hFFFF_FFFF);

    add_row(mk(rsvm_pkg::OP_NOP, 0, 0, 0, 0, 0), 1'b1, 11'd1, rsvm_pkg::ERR_NONE);
    add_row(mk(rsvm_pkg::OP_LABEL, 7, 1, 7, '1, 1023), 1'b1, 11'd2, rsvm_pkg::ERR_NONE);
    add_row(mk(rsvm_pkg::OP_PUTSTR, 0, 0, 0, MinVal, 0), 1'b1, 11'd3, rsvm_pkg::ERR_NONE);
    add_row(mk(rsvm_pkg::OP_PUSH, 0, 0, 0, MaxVal, 0));
    add_row(mk(rsvm_pkg::OP_PUSH, 0, 0, 0, MinVal, 0));
    add_row(mk(rsvm_pkg::OP_POP, 7, 0, 0, 0, 0));
    add_row(mk(rsvm_pkg::OP_POP, 6, 0, 0, 0, 0));
    add_row(mk(rsvm_pkg::OP_MOV, 0, 0, 0, MinVal, 0));
    add_row(mk(rsvm_pkg::OP_MOV, 1, 0, 0, '1, 0));
    // most negative over minus one wraps
    add_row(mk(rsvm_pkg::OP_DIV, 0, 1, 1, 0, 0));
    add_row(mk(rsvm_pkg::OP_ADD, 6, 0, 0, 64'd1, 0));
    add_row(mk(rsvm_pkg::OP_SUB, 0, 0, 0, 64'd1, 0));
    add_row(mk(rsvm_pkg::OP_MUL, 7, 1, 7, 0, 0));
    add_row(mk(rsvm_pkg::OP_MOV, 2, 0, 0, 64'hFFFF_FFFF_FFFF_FFF9, 0));
    add_row(mk(rsvm_pkg::OP_DIV, 2, 0, 0, 64'd2, 0));
    add_row(mk(rsvm_pkg::OP_PUTNUM, 0, 1, 2, 0, 0));
    add_row(mk(rsvm_pkg::OP_PUTNUM, 0, 0, 0, MaxVal, 0));
    add_row(mk(rsvm_pkg::OP_JMP, 0, 0, 0, 0, 1023));
    add_row(mk(rsvm_pkg::OP_JZ, 0, 1, 5, 0, 10));
    add_row(mk(rsvm_pkg::OP_JZ, 0, 0, 0, 64'd3, 20));
    add_row(mk(rsvm_pkg::OP_JNZ, 0, 0, 0, MinVal, 0));
    add_row(mk(rsvm_pkg::OP_JNZ, 0, 1, 5, 0, 500));
    foreach (rows[n]) send(rows[n].ins, rows[n].typed, rows[n].pc_typed, rows[n].err_typed);
    drain();

    write_limit(32'd4000);
    hold_arm = 1'b1;
    random_phase(450);
    drain();
    write_limit(32'hFFFF_FFFE);
    random_phase(450);
    drain();

    // stop the machine once, in one of its ways, then feed it more items
    kind = $urandom_range(0, 5);
    case (kind)
      0: send(mk(rsvm_pkg::OP_HALT, 0, 0, 0, 0, 0));
      1: send(mk(rsvm_pkg::OP_ZERO, 0, 0, 0, 0, 0));
      2: begin
        while (depth_q > 0) send(mk(rsvm_pkg::OP_POP, 3, 0, 0, 0, 0));
        send(mk(rsvm_pkg::OP_POP, 3, 0, 0, 0, 0));
      end
      3: send(mk(rsvm_pkg::OP_DIV, 4, 0, 0, 0, 0));
      4: begin
        while (depth_q < StackDepth) send(mk(rsvm_pkg::OP_PUSH, 0, 0, 0, pick_value(), 0));
        send(mk(rsvm_pkg::OP_PUSH, 0, 0, 0, 0, 0));
      end
      default: begin
        write_limit(32'(steps_q));
        send(random_instr());
      end
    endcase
    for (int k = 0; k < 12; k++) begin
      ins = random_instr();
      ins.mode = rsvm_pkg::op_e'($urandom_range(0, 15));
      send(ins);
    end
    drain();
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
